// ===== rtl/q16a_pkg.sv =====
package q16a_pkg;

	localparam int unsigned DATA_W       = 32;
	localparam int unsigned FRAC_BITS_DEF = 16;

	typedef enum logic [2:0] {
		OP_ADD  = 3'd0,
		OP_SUB  = 3'd1,
		OP_MUL  = 3'd2,
		OP_DIV  = 3'd3,
		OP_NEG  = 3'd4,
		OP_CMP  = 3'd5,
		OP_ITOF = 3'd6,
		OP_FTOI = 3'd7
	} op_t;

	// Per-transaction side data that travels along the divider chain.
	typedef struct packed {
		op_t                op;
		logic [DATA_W-1:0]  res;  // result of every non-divide op
		logic               lt;
		logic               eq;
		logic               dz;   // divide by zero
		logic               neg;  // quotient sign
		logic [DATA_W-1:0]  rem;  // partial remainder
		logic [DATA_W-1:0]  d;    // divisor magnitude
	} side_t;

endpackage

// ===== rtl/q16a_front.sv =====
module q16a_front
	import q16a_pkg::*;
#(
	parameter int unsigned FRAC_BITS = FRAC_BITS_DEF,
	parameter int unsigned W         = DATA_W + FRAC_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_valid,
	input  logic [2:0]               req_type,
	input  logic signed [DATA_W-1:0] operand_a,
	input  logic signed [DATA_W-1:0] operand_b,
	output logic                     out_valid,
	output side_t                    out_side,
	output logic [W-1:0]             out_nq
);

	logic                       valid_s1;
	op_t                        op_s1;
	logic signed [DATA_W-1:0]   a_s1;
	logic signed [DATA_W-1:0]   b_s1;
	logic signed [2*DATA_W-1:0] prod_s1;

	logic                       valid_s2;
	side_t                      side_s2;
	logic [W-1:0]               nq_s2;

	side_t                      side_d;
	logic [W-1:0]               nq_d;
	logic [DATA_W-1:0]          mag_a;
	logic [DATA_W-1:0]          mag_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1   <= op_t'(req_type);
			a_s1    <= operand_a;
			b_s1    <= operand_b;
			prod_s1 <= operand_a * operand_b;
			side_s2 <= side_d;
			nq_s2   <= nq_d;
		end
	end

	always_comb begin
		mag_a = a_s1[DATA_W-1] ? (~a_s1 + 1'b1) : a_s1;
		mag_b = b_s1[DATA_W-1] ? (~b_s1 + 1'b1) : b_s1;

		side_d     = '0;
		side_d.op  = op_s1;
		side_d.neg = a_s1[DATA_W-1] ^ b_s1[DATA_W-1];
		side_d.d   = mag_b;
		side_d.rem = '0;
		nq_d       = {mag_a, {FRAC_BITS{1'b0}}};

		case (op_s1)
			OP_ADD:  side_d.res = a_s1 + b_s1;
			OP_SUB:  side_d.res = a_s1 - b_s1;
			OP_MUL:  side_d.res = prod_s1[FRAC_BITS+DATA_W-1:FRAC_BITS];
			OP_DIV:  side_d.dz  = (b_s1 == '0);
			OP_NEG:  side_d.res = '0 - a_s1;
			OP_CMP: begin
				side_d.lt = (a_s1 < b_s1);
				side_d.eq = (a_s1 == b_s1);
			end
			OP_ITOF: side_d.res = a_s1 << FRAC_BITS;
			OP_FTOI: side_d.res = a_s1 >>> FRAC_BITS;
			default: side_d.res = '0;
		endcase
	end

	assign out_valid = valid_s2;
	assign out_side  = side_s2;
	assign out_nq    = nq_s2;

endmodule

// ===== rtl/q16a_div_cell.sv =====
module q16a_div_cell
	import q16a_pkg::*;
#(
	parameter int unsigned W = DATA_W + FRAC_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic         in_valid,
	input  side_t        in_side,
	input  logic [W-1:0] in_nq,
	output logic         out_valid,
	output side_t        out_side,
	output logic [W-1:0] out_nq
);

	logic              valid_q;
	side_t             side_q;
	logic [W-1:0]      nq_q;

	logic [DATA_W:0]   shifted;
	logic [DATA_W:0]   trial;
	logic              fits;
	side_t             side_d;

	// One restoring step: bring down the next dividend bit, try the subtract.
	always_comb begin
		shifted    = {in_side.rem, in_nq[W-1]};
		trial      = shifted - {1'b0, in_side.d};
		fits       = !trial[DATA_W];
		side_d     = in_side;
		side_d.rem = fits ? trial[DATA_W-1:0] : shifted[DATA_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_q <= side_d;
			nq_q   <= {in_nq[W-2:0], fits};
		end
	end

	assign out_valid = valid_q;
	assign out_side  = side_q;
	assign out_nq    = nq_q;

endmodule

// ===== rtl/q16_fixed_point_alu.sv =====
// Signed fixed-point ALU (Q16.16 by default, FRAC_BITS fraction bits). A request
// carries req_type and two raw 32-bit operands; every request yields exactly one
// response. Add, subtract and negate wrap; multiply keeps bits [FRAC_BITS+31:
// FRAC_BITS] of the full signed product; divide returns the low 32 bits of
// (a << FRAC_BITS) / b truncated toward zero, or 0 with div_by_zero set when b
// is zero; compare sets is_less / is_equal and returns 0. For Q16.16 and any
// other FRAC_BITS the unit takes one request per cycle unless a response stalls,
// and is built from two front stages (operand and product registers, then
// result and magnitude forming), a chain of 32 + FRAC_BITS divider cells that
// each resolve one quotient bit, and the response register. Every op runs
// through the same chain so responses leave in request order. A stalled
// response freezes the whole pipeline, so req_ready is low exactly while
// rsp_valid waits on rsp_ready.
module q16_fixed_point_alu
	import q16a_pkg::*;
#(
	parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     req_valid,
	output logic                     req_ready,
	input  logic [2:0]               req_type,
	input  logic signed [DATA_W-1:0] operand_a,
	input  logic signed [DATA_W-1:0] operand_b,
	output logic                     rsp_valid,
	input  logic                     rsp_ready,
	output logic signed [DATA_W-1:0] result_value,
	output logic                     is_less,
	output logic                     is_equal,
	output logic                     div_by_zero
);

	localparam int unsigned W = DATA_W + FRAC_BITS;

	logic              en;

	logic              valid_c [0:W];
	side_t             side_c  [0:W];
	logic [W-1:0]      nq_c    [0:W];

	logic              rsp_valid_q;
	logic [DATA_W-1:0] result_q;
	logic              less_q;
	logic              equal_q;
	logic              dz_q;

	logic [DATA_W-1:0] quot;
	logic [DATA_W-1:0] result_d;

	// Advance every stage when the response register is free or being drained.
	assign en        = !rsp_valid_q || rsp_ready;
	assign req_ready = en;

	q16a_front #(
		.FRAC_BITS (FRAC_BITS),
		.W         (W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (req_valid),
		.req_type  (req_type),
		.operand_a (operand_a),
		.operand_b (operand_b),
		.out_valid (valid_c[0]),
		.out_side  (side_c[0]),
		.out_nq    (nq_c[0])
	);

	// One cell per quotient bit; the dividend shifts out the top while the
	// quotient shifts in at the bottom of the same word.
	for (genvar i = 0; i < W; i++) begin : g_cell
		q16a_div_cell #(
			.W (W)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (valid_c[i]),
			.in_side   (side_c[i]),
			.in_nq     (nq_c[i]),
			.out_valid (valid_c[i+1]),
			.out_side  (side_c[i+1]),
			.out_nq    (nq_c[i+1])
		);
	end

	// For a divide, apply the quotient sign or drop to zero on divide by zero; other ops pass res on.
	always_comb begin
		quot = nq_c[W][DATA_W-1:0];
		if (side_c[W].op == OP_DIV) begin
			if (side_c[W].dz) begin
				result_d = '0;
			end else if (side_c[W].neg) begin
				result_d = '0 - quot;
			end else begin
				result_d = quot;
			end
		end else begin
			result_d = side_c[W].res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (en) begin
			rsp_valid_q <= valid_c[W];
		end
	end

	// Hold the response payload until the transaction completes.
	always_ff @(posedge clk) begin
		if (en && valid_c[W]) begin
			result_q <= result_d;
			less_q   <= side_c[W].lt;
			equal_q  <= side_c[W].eq;
			dz_q     <= side_c[W].dz;
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign result_value = result_q;
	assign is_less      = less_q;
	assign is_equal     = equal_q;
	assign div_by_zero  = dz_q;

	a_dz_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && div_by_zero |-> result_value == '0 && !is_less && !is_equal)
		else $error("divide by zero response carries nonzero data or compare flags");

	a_cmp_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(is_less && is_equal))
		else $error("is_less and is_equal both set");

	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |-> !req_ready)
		else $error("request accepted while pipeline is frozen");

endmodule

// ===== sim/q16_fixed_point_alu_tb.sv =====
module q16_fixed_point_alu_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import q16a_pkg::*;

	localparam int unsigned FB         = FRAC_BITS_DEF;
	localparam int unsigned RANDOM_CNT = 1000;
	localparam int unsigned IDLE_LIMIT = 1000;  // cycles with no transaction at all
	localparam int unsigned TAIL_WAIT  = 60;    // margin for any response still in the pipeline

	localparam logic signed [31:0] W_MAX = 32'sh7fff_ffff;
	localparam logic signed [31:0] W_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] W_ONE = 32'sh0001_0000;  // 1.0 in Q16.16

	// One request as queued for the driver.
	typedef struct {
		op_t                op;
		logic signed [31:0] a;
		logic signed [31:0] b;
		int unsigned        gap;    // idle cycles before this request is offered
		bit                 drain;  // hold until every pending response is back
	} alu_req_t;

	// One response as the block should return it.
	typedef struct {
		logic signed [31:0] value;
		logic               lt;
		logic               eq;
		logic               dz;
	} alu_rsp_t;

	logic                     clk;
	logic                     arst_n       = 1'b0;
	logic                     req_valid    = 1'b0;
	logic                     req_ready;
	logic [2:0]               req_type     = '0;
	logic signed [DATA_W-1:0] operand_a    = '0;
	logic signed [DATA_W-1:0] operand_b    = '0;
	logic                     rsp_valid;
	logic                     rsp_ready    = 1'b0;
	logic signed [DATA_W-1:0] result_value;
	logic                     is_less;
	logic                     is_equal;
	logic                     div_by_zero;

	alu_req_t    request_q[$];   // requests not yet offered
	alu_rsp_t    response_q[$];  // responses owed by the block, oldest first
	alu_req_t    offered;        // request currently on the request port
	int unsigned gap_cnt;
	int unsigned stall_left;
	int unsigned sent_cnt;
	int unsigned recv_cnt;
	int unsigned total_cnt;
	int unsigned idle_cnt;
	int unsigned err_cnt;

	q16_fixed_point_alu dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.req_type     (req_type),
		.operand_a    (operand_a),
		.operand_b    (operand_b),
		.rsp_valid    (rsp_valid),
		.rsp_ready    (rsp_ready),
		.result_value (result_value),
		.is_less      (is_less),
		.is_equal     (is_equal),
		.div_by_zero  (div_by_zero)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Compute the Q16.16 response for one request. Flags stay low outside
	// their own operation; a divide by zero returns zero with its flag set.
	function automatic alu_rsp_t fixed_alu_result(op_t op, logic signed [31:0] a,
			logic signed [31:0] b);
		alu_rsp_t   r;
		logic [63:0] prod;
		logic [63:0] mag_a;
		logic [63:0] mag_b;
		logic [63:0] quo;
		r = '{value: '0, lt: 1'b0, eq: 1'b0, dz: 1'b0};
		case (op)
			OP_ADD: r.value = a + b;
			OP_SUB: r.value = a - b;
			OP_MUL: begin
				// Low 64 bits of the sign-extended product are exact here.
				prod    = {{32{a[31]}}, a} * {{32{b[31]}}, b};
				r.value = prod[FB +: 32];
			end
			OP_DIV: begin
				if (b == 0) begin
					r.dz = 1'b1;
				end else begin
					mag_a = {{32{a[31]}}, a};
					mag_b = {{32{b[31]}}, b};
					if (a[31])
						mag_a = -mag_a;
					if (b[31])
						mag_b = -mag_b;
					quo = (mag_a << FB) / mag_b;
					if (a[31] ^ b[31])
						quo = -quo;
					r.value = quo[31:0];
				end
			end
			OP_NEG: r.value = -a;
			OP_CMP: begin
				r.lt = a < b;
				r.eq = a == b;
			end
			OP_ITOF: r.value = a << FB;
			default: r.value = a >>> FB;
		endcase
		return r;
	endfunction

	// Draw an operand word: mostly full-range noise, with small Q16.16
	// values, whole numbers, extremes and zero mixed in.
	function automatic logic signed [31:0] random_word();
		logic signed [31:0] w;
		case ($urandom_range(0, 7))
			4: w = $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
			5: begin
				case ($urandom_range(0, 6))
					0: w = W_MAX;
					1: w = W_MIN;
					2: w = 32'sd1;
					3: w = -32'sd1;
					4: w = W_ONE;
					5: w = -W_ONE;
					default: w = '0;
				endcase
			end
			6: w = ($signed($urandom_range(0, 511)) - 256) <<< FB;
			7: w = '0;
			default: w = $urandom();
		endcase
		return w;
	endfunction

	function automatic void queue_request(op_t op, logic signed [31:0] a,
			logic signed [31:0] b, int unsigned gap, bit drain);
		request_q.push_back('{op: op, a: a, b: b, gap: gap, drain: drain});
	endfunction

	// Request driver: offer the next queued request once its gap has passed,
	// and record what the block owes for every accepted transaction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			gap_cnt   <= 0;
			sent_cnt  <= 0;
		end else begin
			if (req_valid && req_ready) begin
				response_q.push_back(fixed_alu_result(offered.op, offered.a, offered.b));
				sent_cnt <= sent_cnt + 1;
			end
			// Hold the payload while the current transaction is still waiting.
			if (!req_valid || req_ready) begin
				if (request_q.size() == 0) begin
					req_valid <= 1'b0;
				end else if (request_q[0].drain && response_q.size() != 0) begin
					// Pause the sender until the pipeline has emptied.
					req_valid <= 1'b0;
				end else if (gap_cnt < request_q[0].gap) begin
					gap_cnt   <= gap_cnt + 1;
					req_valid <= 1'b0;
				end else begin
					offered    = request_q.pop_front();
					gap_cnt   <= 0;
					req_valid <= 1'b1;
					req_type  <= offered.op;
					operand_a <= offered.a;
					operand_b <= offered.b;
				end
			end
		end
	end

	// Response monitor: check each transaction against the oldest owed
	// response, then stall for a random number of cycles. Every third block
	// of responses runs with no stalls at all.
	always @(posedge clk or negedge arst_n) begin
		alu_rsp_t    want;
		int unsigned stall;
		if (!arst_n) begin
			rsp_ready  <= 1'b0;
			stall_left <= 0;
			recv_cnt   <= 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				recv_cnt <= recv_cnt + 1;
				if (response_q.size() == 0) begin
					$error("response with nothing outstanding: value %h", result_value);
					err_cnt++;
				end else begin
					want = response_q.pop_front();
					if (result_value !== want.value) begin
						$error("result_value: expected %h, got %h", want.value, result_value);
						err_cnt++;
					end
					if (is_less !== want.lt) begin
						$error("is_less: expected %b, got %b", want.lt, is_less);
						err_cnt++;
					end
					if (is_equal !== want.eq) begin
						$error("is_equal: expected %b, got %b", want.eq, is_equal);
						err_cnt++;
					end
					if (div_by_zero !== want.dz) begin
						$error("div_by_zero: expected %b, got %b", want.dz, div_by_zero);
						err_cnt++;
					end
				end
				stall = ((recv_cnt / 130) % 3 == 2) ? 0 : $urandom_range(0, 4);
				if (stall == 0) begin
					rsp_ready <= 1'b1;
				end else begin
					rsp_ready  <= 1'b0;
					stall_left <= stall;
				end
			end else if (!rsp_ready) begin
				// Count down the stall, then raise ready again.
				if (stall_left <= 1) begin
					rsp_ready  <= 1'b1;
					stall_left <= 0;
				end else begin
					stall_left <= stall_left - 1;
				end
			end
		end
	end

	// Watchdog: end the run when neither channel has moved for too long.
	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			idle_cnt <= 0;
		end else if (idle_cnt >= IDLE_LIMIT) begin
			$display("q16_fixed_point_alu_tb: done, errors");
			$finish;
		end else begin
			idle_cnt <= idle_cnt + 1;
		end
	end

	initial begin
		op_t         op;
		int unsigned gap;

		// Directed part: operand extremes and the corner of every operation.
		queue_request(OP_ADD,  W_MAX, W_MAX, 0, 0);            // wraps
		queue_request(OP_ADD,  W_MIN, W_MIN, 0, 0);
		queue_request(OP_SUB,  W_MIN, 32'sd1, 1, 0);           // wraps to max
		queue_request(OP_SUB,  '0, W_MIN, 0, 0);
		queue_request(OP_MUL,  W_MAX, W_MAX, 0, 0);
		queue_request(OP_MUL,  W_MIN, W_MIN, 2, 0);
		queue_request(OP_MUL,  W_MIN, W_MAX, 0, 0);
		queue_request(OP_MUL,  -32'sd1, 32'sd1, 0, 0);         // floors to -1
		queue_request(OP_MUL,  32'sh0001_8000, -32'sh0002_4000, 0, 0);
		queue_request(OP_DIV,  W_ONE, '0, 3, 0);               // divide by zero
		queue_request(OP_DIV,  '0, '0, 0, 0);
		queue_request(OP_DIV,  W_MIN, -32'sd1, 0, 0);          // quotient overflow
		queue_request(OP_DIV,  W_ONE, 32'sh0003_0000, 0, 0);
		queue_request(OP_DIV,  -32'sh0007_0000, 32'sh0002_0000, 4, 0);
		queue_request(OP_DIV,  W_MAX, 32'sd1, 0, 0);
		queue_request(OP_DIV,  -32'sd5, W_MAX, 0, 0);          // truncates to zero
		queue_request(OP_NEG,  W_MIN, W_MAX, 0, 0);            // negate of min
		queue_request(OP_NEG,  '0, -32'sd1, 0, 0);
		queue_request(OP_CMP,  W_MIN, W_MIN, 1, 0);
		queue_request(OP_CMP,  W_MIN, W_MAX, 0, 0);
		queue_request(OP_CMP,  W_MAX, -32'sd1, 0, 0);
		queue_request(OP_ITOF, 32'sh1234_5678, W_MIN, 0, 0);   // top bits lost
		queue_request(OP_ITOF, -32'sd3, '0, 0, 0);
		queue_request(OP_FTOI, -32'sd1, W_MAX, 2, 0);          // floors to -1
		queue_request(OP_FTOI, W_MIN, '0, 0, 0);
		queue_request(OP_FTOI, W_MAX, '0, 0, 0);

		// Random part: all ops, phases with and without sender gaps, and a full
		// drain of the pipeline at its start and again halfway through.
		for (int i = 0; i < RANDOM_CNT; i++) begin
			op  = op_t'($urandom_range(0, 7));
			gap = ((i / 150) % 3 == 1) ? 0 : $urandom_range(0, 4);
			queue_request(op, random_word(), random_word(), gap,
				i == 0 || i == RANDOM_CNT / 2);
		end
		total_cnt = request_q.size();

		// Hold reset low, then release it once.
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (sent_cnt != total_cnt)
			@(posedge clk);
		while (response_q.size() != 0)
			@(posedge clk);
		// Give any stray response time to appear before the final report.
		repeat (TAIL_WAIT) @(posedge clk);

		if (err_cnt == 0)
			$display("q16_fixed_point_alu_tb: done, clean");
		else
			$display("q16_fixed_point_alu_tb: done, errors");
		$finish;
	end

endmodule
